[src/dbpc_pkg.sv]
// Shared types, widths and the per-bit counting step of the disjoint bit pair counter.
package dbpc_pkg;

    localparam int VALUE_BITS  = 30;
    localparam int IN_W        = 30;
    localparam int COUNT_OUT_W = 61;
    // 3^VALUE_BITS bounds every count; log2(3) < 1.585
    localparam int CNT_W       = (VALUE_BITS * 1585) / 1000 + 2;
    localparam int NUM_LANES   = 3;

    localparam int IN_TDATA_W  = ((2 * IN_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((COUNT_OUT_W + 7) / 8) * 8;
    localparam int OUT_TUSER_W = 1;

    // lane order: f(hi, hi), f(lo-1, hi), f(lo-1, lo-1)
    localparam int LANE_HH = 0;
    localparam int LANE_MH = 1;
    localparam int LANE_MM = 2;

    // counts per tight/loose state; both-tight is a single path, so one bit
    typedef struct packed {
        logic [CNT_W-1:0] c00;
        logic [CNT_W-1:0] c01;
        logic [CNT_W-1:0] c10;
        logic             tt;
    } lane_t;

    typedef struct packed {
        logic [VALUE_BITS-1:0]  hi;
        logic [VALUE_BITS-1:0]  lm;
        logic                   bad;
        logic                   lz;
        lane_t [NUM_LANES-1:0]  lanes;
    } dp_stage_t;

    typedef struct packed {
        logic [NUM_LANES-1:0][CNT_W-1:0] f;
        logic                            bad;
        logic                            lz;
    } sum_stage_t;

    typedef struct packed {
        logic [CNT_W-1:0] total;
        logic             bad;
    } cmb_stage_t;

    // keep the low VALUE_BITS bits of an input field
    function automatic logic [VALUE_BITS-1:0] fit_val(input logic [IN_W-1:0] v);
        logic [VALUE_BITS-1:0] r;
        r = '0;
        for (int i = 0; i < VALUE_BITS; i++) begin
            if (i < IN_W) begin
                r[i] = v[i];
            end
        end
        return r;
    endfunction

    // one bit of the digit count; digit choices per bit are 00, 10, 01
    function automatic lane_t dp_step(input lane_t c, input logic pb, input logic qb);
        lane_t            n;
        logic [CNT_W-1:0] tt_ext;
        logic [CNT_W-1:0] c00_x3;
        tt_ext = {{(CNT_W-1){1'b0}}, c.tt};
        c00_x3 = (c.c00 << 1) + c.c00;
        n.c00  = c00_x3 + (pb ? (c.c10 << 1) : '0) + (qb ? (c.c01 << 1) : '0)
                 + ((pb && qb) ? tt_ext : '0);
        n.c10  = (pb ? c.c10 : (c.c10 << 1)) + (qb ? tt_ext : '0);
        n.c01  = (qb ? c.c01 : (c.c01 << 1)) + (pb ? tt_ext : '0);
        n.tt   = c.tt & ~(pb & qb);
        return n;
    endfunction

endpackage

[src/disjoint_bit_pair_counter.sv]
// Top level: pipelined counter of ordered pairs in [low, high] with zero bitwise AND.
//
// Input stream (s_axis_*): one word per range, range_low and range_high in tdata.
// Output stream (m_axis_*): one word per range, pair_count in tdata and the
// bad_range flag in tuser. bad_range is set when range_low > range_high; the
// count is then zero.
// The count is f(hi,hi) - 2*f(lo-1,hi) + f(lo-1,lo-1); the three f terms run as
// parallel lanes through one pipeline stage per value bit, top bit first.
// An accepted word passes the input register, which loads at the accepting edge,
// one stage per bit, the lane sum, the final combine and the output register
// before it can show on m_axis_tvalid.
// Throughput: one word per cycle, set by the per-bit stages, unless the skid is full.
// A two-entry output buffer (output register plus skid) sits at the end; when
// the receiver stalls, the pipeline keeps accepting until the skid fills, then
// s_axis_tready drops and every stage holds. Nothing is lost or repeated.
// Reset (rst_n low, asynchronous) clears all valid bits and the output buffer;
// s_axis_tready is high right after reset.
module disjoint_bit_pair_counter (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [29:0] range_low, [59:30] range_high, rest zero
    input  logic [dbpc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [60:0] pair_count, rest zero
    output logic [dbpc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // [0] bad_range
    output logic [dbpc_pkg::OUT_TUSER_W-1:0] m_axis_tuser
);
    import dbpc_pkg::*;

    dp_stage_t  st_reg  [0:VALUE_BITS];
    logic       vld_reg [0:VALUE_BITS];
    sum_stage_t sum_reg;
    logic       sum_vld_reg;
    cmb_stage_t cmb_reg;
    logic       cmb_vld_reg;

    cmb_stage_t out_reg;
    logic       out_vld_reg;
    cmb_stage_t skid_reg;
    logic       skid_full_reg;

    logic en;
    logic push;
    logic pop;

    // pipeline moves unless the skid is holding a word
    assign en            = ~skid_full_reg;
    assign s_axis_tready = en;
    assign push          = en & cmb_vld_reg;
    assign pop           = out_vld_reg & m_axis_tready;

    // ---- stage 0: capture range, compare, lo-1 ----
    logic [VALUE_BITS-1:0] in_lo;
    logic [VALUE_BITS-1:0] in_hi;
    dp_stage_t             st0_next;

    assign in_lo = fit_val(s_axis_tdata[IN_W-1:0]);
    assign in_hi = fit_val(s_axis_tdata[2*IN_W-1:IN_W]);

    always_comb
    begin
        st0_next.hi  = in_hi;
        st0_next.lm  = in_lo - {{(VALUE_BITS-1){1'b0}}, 1'b1};
        st0_next.bad = (in_lo > in_hi);
        st0_next.lz  = (in_lo == '0);
        for (int l = 0; l < NUM_LANES; l++)
        begin
            st0_next.lanes[l].c00 = '0;
            st0_next.lanes[l].c01 = '0;
            st0_next.lanes[l].c10 = '0;
            st0_next.lanes[l].tt  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg[0] <= st0_next;
        end
    end

    // ---- stages 1..VALUE_BITS: one value bit each, top bit first ----
    for (genvar k = 1; k <= VALUE_BITS; k++)
    begin : g_bit
        localparam int BIT = VALUE_BITS - k;
        dp_stage_t st_next;

        always_comb
        begin
            st_next = st_reg[k-1];
            st_next.lanes[LANE_HH] = dp_step(st_reg[k-1].lanes[LANE_HH],
                                             st_reg[k-1].hi[BIT], st_reg[k-1].hi[BIT]);
            st_next.lanes[LANE_MH] = dp_step(st_reg[k-1].lanes[LANE_MH],
                                             st_reg[k-1].lm[BIT], st_reg[k-1].hi[BIT]);
            st_next.lanes[LANE_MM] = dp_step(st_reg[k-1].lanes[LANE_MM],
                                             st_reg[k-1].lm[BIT], st_reg[k-1].lm[BIT]);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                st_reg[k] <= st_next;
            end
        end
    end

    // ---- lane sum: f = c00 + c01 + c10 + tt ----
    sum_stage_t sum_next;

    always_comb
    begin
        sum_next.bad = st_reg[VALUE_BITS].bad;
        sum_next.lz  = st_reg[VALUE_BITS].lz;
        for (int l = 0; l < NUM_LANES; l++)
        begin
            sum_next.f[l] = (st_reg[VALUE_BITS].lanes[l].c00 + st_reg[VALUE_BITS].lanes[l].c01)
                          + (st_reg[VALUE_BITS].lanes[l].c10
                             + {{(CNT_W-1){1'b0}}, st_reg[VALUE_BITS].lanes[l].tt});
        end
    end

    // ---- combine: f(hi,hi) - 2 f(lo-1,hi) + f(lo-1,lo-1), unless bad or lo = 0 ----
    cmb_stage_t cmb_next;

    always_comb
    begin
        cmb_next.bad = sum_reg.bad;
        if (sum_reg.bad)
        begin
            cmb_next.total = '0;
        end
        else if (sum_reg.lz)
        begin
            cmb_next.total = sum_reg.f[LANE_HH];
        end
        else
        begin
            cmb_next.total = sum_reg.f[LANE_HH] - (sum_reg.f[LANE_MH] << 1)
                           + sum_reg.f[LANE_MM];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_vld_reg <= 1'b0;
            cmb_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            sum_vld_reg <= vld_reg[VALUE_BITS];
            cmb_vld_reg <= sum_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_reg <= sum_next;
            cmb_reg <= cmb_next;
        end
    end

    // ---- output register plus skid ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg   <= 1'b0;
            skid_full_reg <= 1'b0;
        end
        else if (skid_full_reg)
        begin
            if (pop)
            begin
                skid_full_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (out_vld_reg && !pop)
            begin
                skid_full_reg <= 1'b1;
            end
            else
            begin
                out_vld_reg <= 1'b1;
            end
        end
        else if (pop)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_full_reg)
        begin
            if (pop)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (push)
        begin
            if (out_vld_reg && !pop)
            begin
                skid_reg <= cmb_reg;
            end
            else
            begin
                out_reg <= cmb_reg;
            end
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W-CNT_W){1'b0}}, out_reg.total};
    assign m_axis_tuser  = out_reg.bad;

endmodule

[src/dbpc_checker.sv]
// Port-level checker for the disjoint bit pair counter, with its bind.
module dbpc_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic [dbpc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [dbpc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [dbpc_pkg::OUT_TUSER_W-1:0] m_axis_tuser
);
    import dbpc_pkg::*;

    // stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("output word changed while stalled");

    // input side only backs off while an output word is waiting
    a_ready_back: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("tready low with no output pending");

    // ready drops only after a stalled cycle on the output
    a_ready_fall: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(s_axis_tready) |-> $past(m_axis_tvalid && !m_axis_tready))
        else $error("tready dropped without an output stall");

    // bad range forces a zero count
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == '0))
        else $error("bad range with nonzero count");

endmodule

bind disjoint_bit_pair_counter dbpc_checker u_dbpc_checker (.*);

[bench/disjoint_bit_pair_counter_checker.sv]
// Checker for the disjoint bit pair counter: predicts every count and compares the output words.
`timescale 1ns / 100ps

module disjoint_bit_pair_counter_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [dbpc_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [dbpc_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  logic [dbpc_pkg::OUT_TUSER_W-1:0] m_tuser,
    output int                               fail_count,
    output int                               counts_waiting
);

    import dbpc_pkg::*;

    localparam int MAX_LINES = 40;

    typedef struct packed {
        logic [COUNT_OUT_W-1:0] pair_count;
        logic                   bad_range;
    } pair_result_t;

    pair_result_t expected_counts[$];

    // pairs x <= p, y <= q with x & y == 0; digit count from the top bit,
    // index [x still tight][y still tight]
    function automatic longint unsigned disjoint_pairs_upto(
        input logic [VALUE_BITS-1:0] p,
        input logic [VALUE_BITS-1:0] q
    );
        longint unsigned ways [2][2];
        longint unsigned next_ways [2][2];
        longint unsigned sum;
        bit              nx;
        bit              ny;
        ways = '{'{0, 0}, '{0, 1}};
        for (int b = VALUE_BITS - 1; b >= 0; b--)
        begin
            next_ways = '{'{0, 0}, '{0, 0}};
            for (int tx = 0; tx < 2; tx++)
            begin
                for (int ty = 0; ty < 2; ty++)
                begin
                    for (int xb = 0; xb < 2; xb++)
                    begin
                        for (int yb = 0; yb < 2; yb++)
                        begin
                            // both bits set is the one forbidden digit pair
                            if (!(xb && yb) && !(tx && xb > p[b]) && !(ty && yb > q[b]))
                            begin
                                nx = tx && (xb == p[b]);
                                ny = ty && (yb == q[b]);
                                next_ways[nx][ny] += ways[tx][ty];
                            end
                        end
                    end
                end
            end
            ways = next_ways;
        end
        sum = ways[0][0] + ways[0][1] + ways[1][0] + ways[1][1];
        return sum;
    endfunction

    // inclusion-exclusion over the square [lo, hi] x [lo, hi]
    function automatic pair_result_t range_pair_total(
        input logic [VALUE_BITS-1:0] lo,
        input logic [VALUE_BITS-1:0] hi
    );
        pair_result_t    r;
        longint unsigned total;
        logic [VALUE_BITS-1:0] below;
        r = '0;
        if (lo > hi)
        begin
            r.bad_range = 1'b1;
            return r;
        end
        total = disjoint_pairs_upto(hi, hi);
        if (lo != 0)
        begin
            below = lo - 1'b1;
            total = total - 2 * disjoint_pairs_upto(below, hi)
                    + disjoint_pairs_upto(below, below);
        end
        r.pair_count = total[COUNT_OUT_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        if (fail_count < MAX_LINES)
        begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
        fail_count++;
    endtask

    initial
    begin
        fail_count     = 0;
        counts_waiting = 0;
    end

    always @(posedge clk)
    begin
        pair_result_t want;
        logic [COUNT_OUT_W-1:0] got_count;
        logic                   got_bad;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                expected_counts.push_back(range_pair_total(s_tdata[VALUE_BITS-1:0],
                                                           s_tdata[IN_W +: VALUE_BITS]));
            end
            if (m_tvalid && m_tready)
            begin
                got_count = m_tdata[COUNT_OUT_W-1:0];
                got_bad   = m_tuser[0];
                if (expected_counts.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected word count=%0d bad=%0b",
                                              got_count, got_bad));
                end
                else
                begin
                    want = expected_counts.pop_front();
                    if (got_count !== want.pair_count)
                    begin
                        report_mismatch($sformatf("pair_count %0d, want %0d",
                                                  got_count, want.pair_count));
                    end
                    if (got_bad !== want.bad_range)
                    begin
                        report_mismatch($sformatf("bad_range %0b, want %0b",
                                                  got_bad, want.bad_range));
                    end
                end
            end
            counts_waiting <= expected_counts.size();
        end
    end

endmodule

[bench/testbench.sv]
// Testbench top: drives ranges into the pair counter, toggles stalls and gives the verdict.
`timescale 1ns / 100ps

module testbench;

    import dbpc_pkg::*;

    localparam int                    RANDOM_PER_PHASE = 500;
    localparam int                    DRAIN_CYCLES     = 2 * (VALUE_BITS + 3);
    localparam int                    CYCLE_LIMIT      = 400000;
    localparam logic [VALUE_BITS-1:0] VMAX             = '1;
    localparam logic [VALUE_BITS-1:0] VTOP             = 1 << (VALUE_BITS - 1);

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [OUT_TUSER_W-1:0] m_axis_tuser;

    int fail_count;
    int counts_waiting;
    int tx_idle_pct = 17;
    int rx_stall_pct = 73;
    int cycle_count = 0;

    always #10 clk = ~clk;

    disjoint_bit_pair_counter u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    disjoint_bit_pair_counter_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_axis_tvalid),
        .s_tready       (s_axis_tready),
        .s_tdata        (s_axis_tdata),
        .m_tvalid       (m_axis_tvalid),
        .m_tready       (m_axis_tready),
        .m_tdata        (m_axis_tdata),
        .m_tuser        (m_axis_tuser),
        .fail_count     (fail_count),
        .counts_waiting (counts_waiting)
    );

    // receiver back-pressure, redrawn every cycle
    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // one range word; tvalid stays high straight into the next word when no gap is drawn
    task automatic send_range(input logic [VALUE_BITS-1:0] lo, input logic [VALUE_BITS-1:0] hi);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_TDATA_W - 2 * IN_W){1'b0}}, hi, lo};
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
    endtask

    // random value of random bit length, so small ranges are common
    function automatic logic [VALUE_BITS-1:0] random_value();
        logic [VALUE_BITS-1:0] v;
        int                    len;
        len = $urandom_range(VALUE_BITS, 1);
        v   = VALUE_BITS'($urandom);
        return v & ((VALUE_BITS'(1) << len) - 1'b1 | (len == VALUE_BITS ? VMAX : '0));
    endfunction

    task automatic send_random_ranges(input int n);
        logic [VALUE_BITS-1:0] a;
        logic [VALUE_BITS-1:0] b;
        logic [VALUE_BITS-1:0] t;
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(9))
                0:
                begin
                    // full-width, any order, so low > high shows up too
                    a = VALUE_BITS'($urandom);
                    b = VALUE_BITS'($urandom);
                end
                1:
                begin
                    a = 0;
                    b = random_value();
                end
                2:
                begin
                    // narrow window
                    a = random_value();
                    b = a + VALUE_BITS'($urandom_range(8));
                    if (b < a)
                    begin
                        b = VMAX;
                    end
                end
                3:
                begin
                    // inverted on purpose
                    a = random_value();
                    b = random_value();
                    if (a <= b)
                    begin
                        t = a;
                        a = b;
                        b = t;
                    end
                    if (a == b)
                    begin
                        b = a - 1'b1;
                        if (a == 0)
                        begin
                            a = 1;
                            b = 0;
                        end
                    end
                end
                4:
                begin
                    a = random_value();
                    b = VMAX;
                end
                default:
                begin
                    a = random_value();
                    b = random_value();
                    if (a > b)
                    begin
                        t = a;
                        a = b;
                        b = t;
                    end
                end
            endcase
            send_range(a, b);
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // phase 1: sender idles now and then, receiver mostly stalled
        tx_idle_pct  = 17;
        rx_stall_pct = 73;

        // corner ranges: extremes, single values, low above high, alternating bits
        send_range(0, 0);
        send_range(0, 1);
        send_range(1, 1);
        send_range(0, VMAX);
        send_range(VMAX, VMAX);
        send_range(1, VMAX);
        send_range(VMAX - 1'b1, VMAX);
        send_range(VTOP, VMAX);
        send_range(VTOP - 1'b1, VTOP);
        send_range(0, VTOP - 1'b1);
        send_range(7, 7);
        send_range(VALUE_BITS'(30'h1555_5555), VALUE_BITS'(30'h2AAA_AAAA));
        send_range(1, 0);
        send_range(VMAX, 0);
        send_range(VMAX, VMAX - 1'b1);
        send_range(5, 3);
        send_range(VALUE_BITS'(30'h2AAA_AAAA), VALUE_BITS'(30'h1555_5555));
        send_range(VTOP, VTOP - 1'b1);
        send_random_ranges(RANDOM_PER_PHASE);

        // phase 2: roles swapped
        tx_idle_pct  = 73;
        rx_stall_pct = 17;
        send_random_ranges(RANDOM_PER_PHASE);

        // phase 3: full rate both ways
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        send_random_ranges(RANDOM_PER_PHASE);
        s_axis_tvalid <= 1'b0;

        // let the checker see the last accepted word, then drain
        repeat (2) @(posedge clk);
        while (counts_waiting != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
